FILE: hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// shared types, constants and hex helpers for the url percent decoder
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int         PADDR_W       = 3;
    localparam int         PDATA_W       = 32;
    localparam logic [PADDR_W-1:0] REG_PLUS_ADDR = 3'd0;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    // one accepted byte worth of output, first byte in slot 0
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } t_job;

    function automatic logic hex_ok(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 4'(b - 8'h61 + 8'd10);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 4'(b - 8'h41 + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/upd_if.sv
// ----------------------------------------------------------------------------
// upd_if
// valid/ready channels for raw input bytes and decoded output bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// accepts raw bytes, tracks the open escape and builds output jobs
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_plus_to_space,
    input  wire logic i_q_full,
    upd_in_if.sink    i_in,
    output t_job      o_job,
    output logic      o_push
);

    logic [1:0] r_held_count, n_held_count;
    logic [7:0] r_held_digit, n_held_digit;

    logic       accept;
    logic [7:0] b;
    logic       last;
    logic       b_hex;
    logic       fr_emit;
    logic [7:0] fr_byte;
    logic [1:0] fr_held;
    t_job       job;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign b          = i_in.in_byte;
    assign last       = i_in.in_last;
    assign b_hex      = hex_ok(b);

    // byte handled with nothing held
    always_comb begin
        fr_emit = !(b == CH_PERCENT && !last);
        fr_byte = (b == CH_PLUS && i_plus_to_space) ? CH_SPACE : b;
        fr_held = fr_emit ? HELD_NONE : HELD_PCT;
    end

    always_comb begin
        job          = '0;
        job.last     = last;
        n_held_count = HELD_NONE;
        n_held_digit = r_held_digit;
        case (r_held_count)
            HELD_PCT: begin
                if (b_hex && !last) begin
                    n_held_count = HELD_DIGIT;
                    n_held_digit = b;
                end else if (b_hex) begin
                    job.bytes[0] = CH_PERCENT;
                    job.bytes[1] = b;
                    job.count    = 2'd2;
                end else begin
                    job.bytes[0] = CH_PERCENT;
                    job.bytes[1] = fr_byte;
                    job.count    = fr_emit ? 2'd2 : 2'd1;
                    n_held_count = fr_held;
                end
            end
            HELD_DIGIT: begin
                if (b_hex) begin
                    job.bytes[0] = {hex_nibble(r_held_digit), hex_nibble(b)};
                    job.count    = 2'd1;
                end else begin
                    job.bytes[0] = CH_PERCENT;
                    job.bytes[1] = r_held_digit;
                    job.bytes[2] = fr_byte;
                    job.count    = fr_emit ? 2'd3 : 2'd2;
                    n_held_count = fr_held;
                end
            end
            default: begin
                job.bytes[0] = fr_byte;
                job.count    = fr_emit ? 2'd1 : 2'd0;
                n_held_count = fr_held;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= HELD_NONE;
            r_held_digit <= 8'd0;
        end else if (accept) begin
            r_held_count <= n_held_count;
            r_held_digit <= n_held_digit;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.count != 2'd0);

endmodule

`default_nettype wire

FILE: hw/rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// short job fifo between the front and back halves
// ----------------------------------------------------------------------------
`default_nettype none

module upd_queue
    import upd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_full,
    output logic      o_empty
);

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_fill;

    assign o_full  = (r_fill == (QAW+1)'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// walks the head job one byte per transfer into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_job      i_head,
    input  wire logic i_empty,
    output logic      o_pop,
    upd_out_if.source o_out
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_idx;

    logic load;
    logic take;
    logic is_final;

    assign load     = !r_valid || o_out.ready;
    assign take     = load && !i_empty;
    assign is_final = (r_idx == 2'(i_head.count - 2'd1));
    assign o_pop    = take && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_idx   <= is_final ? 2'd0 : r_idx + 2'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= i_head.last && is_final;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

endmodule

`default_nettype wire

FILE: hw/rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// streaming percent decoder with optional plus-to-space mapping
// ----------------------------------------------------------------------------
// path: decoded bytes pass through the job queue, then the output register
// throughput: one input byte per cycle unless the queue is full, one output
//   byte per cycle while ready is high; an input that yields two or three
//   bytes takes as many transfers, and the four-entry job queue absorbs it
// reset: synchronous active low, clears escape state, queue and register
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    upd_in_if.sink                  i_in,
    upd_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic r_plus_to_space;
    logic plus_sel;
    t_job front_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign pready   = 1'b1;
    assign plus_sel = (paddr[PADDR_W-1:2] == REG_PLUS_ADDR[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_to_space <= 1'b0;
        end else if (psel && penable && pwrite && plus_sel) begin
            r_plus_to_space <= pwdata[0];
        end
    end

    assign prdata = plus_sel ? {{(PDATA_W-1){1'b0}}, r_plus_to_space} : '0;

    upd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_plus_to_space (r_plus_to_space),
        .i_q_full        (q_full),
        .i_in            (i_in),
        .o_job           (front_job),
        .o_push          (push)
    );

    upd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// percent decoder bench: a directed table of byte strings, then random
// strings in three idle-rate phases, every output transfer checked against
// the table or in-bench decoder; one long receiver hold-off backs the queue up
// ----------------------------------------------------------------------------

module tb_top;
    import upd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_AT_RX     = 80;
    localparam int PHASE_ITEMS    = 112;
    localparam logic [PADDR_W-1:0] STRAY_ADDR = PADDR_W'(4);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_op;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_row_chk;

    typedef struct packed {
        t_row_op    op;
        logic [7:0] data;
        logic       last;
        t_row_chk   chk;
        logic [7:0] exp;
    } t_dir_row;

    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{ROW_BYTE, 8'h00,      1'b0, CHK_ONE,   8'h00},
        '{ROW_BYTE, 8'hFF,      1'b0, CHK_ONE,   8'hFF},
        '{ROW_BYTE, CH_PLUS,    1'b0, CHK_ONE,   CH_PLUS},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "4",        1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "1",        1'b0, CHK_ONE,   8'h41},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "f",        1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "A",        1'b1, CHK_ONE,   8'hFA},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "G",        1'b0, CHK_MODEL, 8'h00},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "3",        1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "z",        1'b0, CHK_MODEL, 8'h00},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_MODEL, 8'h00},
        '{ROW_BYTE, "4",        1'b1, CHK_MODEL, 8'h00},
        '{ROW_BYTE, CH_PERCENT, 1'b1, CHK_ONE,   CH_PERCENT},
        '{ROW_CFG,  8'h01,      1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, CH_PLUS,    1'b0, CHK_ONE,   CH_SPACE},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "2",        1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, CH_PLUS,    1'b1, CHK_MODEL, 8'h00},
        '{ROW_BYTE, CH_PERCENT, 1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "2",        1'b0, CHK_NONE,  8'h00},
        '{ROW_BYTE, "B",        1'b1, CHK_ONE,   CH_PLUS}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    url_percent_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_dec_byte  decoded_q [$];
    t_dec_byte  step_q [$];
    logic [1:0] esc_cnt;
    logic [7:0] esc_digit;
    logic       plus_sp;
    int         src_idle;
    int         snk_idle;
    int         err_cnt;
    int         idle_run = 0;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // decoder mirror
    function automatic logic hex_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    task automatic emit(input logic [7:0] c);
        step_q.insert(step_q.size(), '{data: c, last: 1'b0});
    endtask

    task automatic fresh_byte(input logic [7:0] c, input logic l);
        if (c == CH_PERCENT && !l) begin
            esc_cnt = HELD_PCT;
        end else if (c == CH_PLUS && plus_sp) begin
            emit(CH_SPACE);
        end else begin
            emit(c);
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic l);
        logic [1:0] prev;
        prev = esc_cnt;
        esc_cnt = HELD_NONE;
        step_q.delete();
        case (prev)
            HELD_PCT: begin
                if (!hex_char(c)) begin
                    emit(CH_PERCENT);
                    fresh_byte(c, l);
                end else if (l) begin
                    emit(CH_PERCENT);
                    emit(c);
                end else begin
                    esc_cnt = HELD_DIGIT;
                    esc_digit = c;
                end
            end
            HELD_DIGIT: begin
                if (hex_char(c)) begin
                    emit({hex_val(esc_digit), hex_val(c)});
                end else begin
                    emit(CH_PERCENT);
                    emit(esc_digit);
                    fresh_byte(c, l);
                end
            end
            default: fresh_byte(c, l);
        endcase
        if (l) begin
            esc_cnt = HELD_NONE;
            if (step_q.size() > 0) begin
                step_q[step_q.size() - 1].last = 1'b1;
            end
        end
    endtask

    // stimulus helpers
    function automatic logic [7:0] hex_digit();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) begin
            return 8'h30 + 8'(v);
        end else if (v < 16) begin
            return 8'h61 + 8'(v - 10);
        end
        return 8'h41 + 8'(v - 16);
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return CH_PERCENT;
        end else if (r < 40) begin
            return hex_digit();
        end else if (r < 50) begin
            return CH_PLUS;
        end else if (r < 62) begin
            // just outside the hex ranges
            case ($urandom_range(0, 5))
                0: return 8'h2F;
                1: return 8'h3A;
                2: return 8'h40;
                3: return 8'h47;
                4: return 8'h60;
                default: return 8'h67;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic l);
        @(negedge clk);
        while (int'($urandom_range(0, 99)) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.in_last <= l;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (a == REG_PLUS_ADDR) begin
            plus_sp = d[0];
        end
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (a == REG_PLUS_ADDR && prdata !== d) begin
            $error("prdata: expected %h, got %h", d, prdata);
            err_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic plus_v,
                             input logic stray);
        logic [7:0] str_q [$];
        logic       l;
        int         sent;
        drain();
        src_idle = tx_pct;
        snk_idle = rx_pct;
        reg_write(REG_PLUS_ADDR, PDATA_W'(plus_v));
        if (stray) begin
            reg_write(STRAY_ADDR, '1);
        end
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            str_q.delete();
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 99) < 35) begin
                    str_q.insert(str_q.size(), CH_PERCENT);
                    repeat (2) begin
                        str_q.insert(str_q.size(),
                                     ($urandom_range(0, 99) < 85) ? hex_digit()
                                                                  : noise_byte());
                    end
                end else begin
                    str_q.insert(str_q.size(), noise_byte());
                end
            end
            foreach (str_q[k]) begin
                l = (k == str_q.size() - 1);
                send_byte(str_q[k], l);
                decode_byte(str_q[k], l);
                foreach (step_q[j]) decoded_q.insert(decoded_q.size(), step_q[j]);
                sent++;
            end
        end
    endtask

    // output side: check each transfer, drive ready
    initial begin
        int        n_rx;
        int        hold;
        t_dec_byte want;
        n_rx = 0;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                n_rx++;
                if (n_rx == HOLD_AT_RX) begin
                    hold = HOLD_CYCLES;
                end
                if (decoded_q.size() == 0) begin
                    $error("transfer with nothing expected: out_byte %h out_last %b",
                           out_ch.out_byte, out_ch.out_last);
                    err_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (out_ch.out_byte !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
                        err_cnt++;
                    end
                    if (out_ch.out_last !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, out_ch.out_last);
                        err_cnt++;
                    end
                end
            end
            @(negedge clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= (int'($urandom_range(0, 99)) >= snk_idle);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int r;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rst_n     = 1'b0;
        err_cnt   = 0;
        esc_cnt   = HELD_NONE;
        esc_digit = 8'h00;
        plus_sp   = 1'b0;
        src_idle  = 24;
        snk_idle  = 60;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].op == ROW_CFG) begin
                drain();
                reg_write(REG_PLUS_ADDR, PDATA_W'(DIR_TAB[r].data));
            end else begin
                send_byte(DIR_TAB[r].data, DIR_TAB[r].last);
                decode_byte(DIR_TAB[r].data, DIR_TAB[r].last);
                case (DIR_TAB[r].chk)
                    CHK_MODEL: begin
                        foreach (step_q[j]) decoded_q.insert(decoded_q.size(), step_q[j]);
                    end
                    CHK_ONE: begin
                        decoded_q.insert(decoded_q.size(),
                                         '{data: DIR_TAB[r].exp, last: DIR_TAB[r].last});
                    end
                    default: ;
                endcase
            end
        end

        run_phase(24, 60, 1'b0, 1'b0);
        run_phase(60, 24, 1'b1, 1'b0);
        run_phase(0, 0, 1'($urandom_range(0, 1)), 1'b1);
        drain();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_if.sv
hw/rtl/upd_front.sv
hw/rtl/upd_queue.sv
hw/rtl/upd_back.sv
hw/rtl/url_percent_decoder.sv
tb/tb_top.sv
